[rtl/core/steering_position_pid_assert.svh]
// Assertion macros for the steering position controller.
// Used by the modules that check their own control sequencing.
`ifndef STEERING_POSITION_PID_ASSERT_SVH
`define STEERING_POSITION_PID_ASSERT_SVH

// same-cycle implication
`define SPP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("steering_position_pid: same-cycle check failed");

// next-cycle implication
`define SPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("steering_position_pid: next-cycle check failed");

`endif

[rtl/core/spp_pkg.sv]
// Shared types and constants of the steering position controller.
// No dependencies.
package spp_pkg;

  localparam int DIV_NW    = 40;
  localparam int DIV_DW    = 16;
  localparam int DIV_STEPS = DIV_NW / 2;
  localparam int DIV_CW    = 5;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 20;

  localparam logic [CFG_IW-1:0] CFG_FILTER_GAIN = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_PROP_GAIN   = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_INTEG_GAIN  = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_DERIV_GAIN  = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_DEADBAND    = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_POWER_LIMIT = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_TICK_PERIOD = 3'd6;

  localparam logic [7:0] MODE_RADIO = 8'd1;
  localparam logic [7:0] MODE_NAV   = 8'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MUL_F1, ST_MUL_F2, ST_POT, ST_MAP_MUL, ST_MAP_DIVS, ST_MAP_WAIT,
    ST_ANGLE, ST_ERR, ST_INTEG, ST_ILO, ST_IHI, ST_ITERM, ST_DER_MUL, ST_DER_DIVS,
    ST_DER_WAIT, ST_PROP, ST_SUM, ST_OUT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_FILT1, OP_FILT2, OP_POT, OP_MAP_MUL, OP_MAP_DIV, OP_ANGLE,
    OP_ERR, OP_INTEG, OP_ILO, OP_IHI, OP_ITERM, OP_DER_MUL, OP_DER_DIV, OP_PROP,
    OP_SUM, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } stat_t;

endpackage

[rtl/core/steering_position_pid.sv]
// Steering position PID: low-pass filtered pot angle, setpoint select, PID, clamp.
// One control tick at a time: a new input beat is taken only when idle, once the
// last result is loaded. The angle map and derivative term share the radix-4 divider.
// Synchronous active-low reset restores register defaults and clears filter,
// integral and previous error. Depends on spp_pkg, spp_ctrl, spp_dpath, spp_div.
module steering_position_pid #(
  parameter int SAMPLE_BITS = 12,
  parameter int LEFT_POT    = 3210,
  parameter int CENTER_POT  = 1730,
  parameter int RIGHT_POT   = 490,
  parameter int ANGLE_LIMIT = 15729
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [SAMPLE_BITS-1:0]     in_pot_sample,
  input  logic [7:0]                 in_mode,
  input  logic signed [15:0]         in_radio_steer,
  input  logic signed [15:0]         in_nav_steer,
  input  logic                       in_link_ok,
  input  logic                       in_nav_ok,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_drive_level,
  output logic                       out_drive_left,
  output logic                       out_drive_write,
  output logic [11:0]                out_filtered_pot,
  output logic signed [15:0]         out_measured_angle,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [spp_pkg::CFG_IW-1:0] cfg_index,
  input  logic [spp_pkg::CFG_DW-1:0] cfg_data
);
  import spp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  spp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  spp_dpath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .LEFT_POT    (LEFT_POT),
    .CENTER_POT  (CENTER_POT),
    .RIGHT_POT   (RIGHT_POT),
    .ANGLE_LIMIT (ANGLE_LIMIT)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_pot_sample      (in_pot_sample),
    .in_mode            (in_mode),
    .in_radio_steer     (in_radio_steer),
    .in_nav_steer       (in_nav_steer),
    .in_link_ok         (in_link_ok),
    .in_nav_ok          (in_nav_ok),
    .out_drive_level    (out_drive_level),
    .out_drive_left     (out_drive_left),
    .out_drive_write    (out_drive_write),
    .out_filtered_pot   (out_filtered_pot),
    .out_measured_angle (out_measured_angle)
  );

endmodule

[rtl/core/spp_div.sv]
// Radix-4 restoring unsigned divider, two quotient bits per cycle.
// Depends on spp_pkg.
module spp_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [spp_pkg::DIV_NW-1:0] dividend,
  input  logic [spp_pkg::DIV_DW-1:0] divisor,
  output logic                       busy,
  output logic [spp_pkg::DIV_NW-1:0] quotient
);
  import spp_pkg::*;

  logic              busy_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_NW-1:0] quo_r, quo_nxt;
  logic [DIV_DW:0]   rem_r, rem_nxt;
  logic [DIV_DW-1:0] div_r;

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int i = 0; i < 2; i++) begin
      rem_nxt = {rem_nxt[DIV_DW-1:0], quo_nxt[DIV_NW-1]};
      quo_nxt = {quo_nxt[DIV_NW-2:0], 1'b0};
      if (rem_nxt >= {1'b0, div_r}) begin
        rem_nxt    = rem_nxt - {1'b0, div_r};
        quo_nxt[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CW'(DIV_STEPS - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

[rtl/core/spp_dpath.sv]
// Datapath: config registers, filter, angle map and PID arithmetic on one
// shared multiplier and one divider. Depends on spp_pkg and spp_div.
module spp_dpath #(
  parameter int SAMPLE_BITS = 12,
  parameter int LEFT_POT    = 3210,
  parameter int CENTER_POT  = 1730,
  parameter int RIGHT_POT   = 490,
  parameter int ANGLE_LIMIT = 15729
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  spp_pkg::cmd_t              cmd,
  output spp_pkg::stat_t             stat,
  input  logic                       cfg_valid,
  input  logic [spp_pkg::CFG_IW-1:0] cfg_index,
  input  logic [spp_pkg::CFG_DW-1:0] cfg_data,
  input  logic [SAMPLE_BITS-1:0]     in_pot_sample,
  input  logic [7:0]                 in_mode,
  input  logic signed [15:0]         in_radio_steer,
  input  logic signed [15:0]         in_nav_steer,
  input  logic                       in_link_ok,
  input  logic                       in_nav_ok,
  output logic [7:0]                 out_drive_level,
  output logic                       out_drive_left,
  output logic                       out_drive_write,
  output logic [11:0]                out_filtered_pot,
  output logic signed [15:0]         out_measured_angle
);
  import spp_pkg::*;

  localparam int FW     = SAMPLE_BITS + 16;
  localparam int DEN_L  = LEFT_POT - CENTER_POT;
  localparam int DEN_R  = CENTER_POT - RIGHT_POT;
  localparam int MAG_L  = (DEN_L < 0) ? -DEN_L : ((DEN_L == 0) ? 1 : DEN_L);
  localparam int MAG_R  = (DEN_R < 0) ? -DEN_R : ((DEN_R == 0) ? 1 : DEN_R);
  localparam int HALF_L = MAG_L / 2;
  localparam int HALF_R = MAG_R / 2;
  localparam logic signed [69:0] TSAT = 70'sd1 <<< 60;
  localparam logic signed [47:0] IMAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] IMIN = {1'b1, {47{1'b0}}};

  logic [15:0] filt_gain_r, tick_period_r, dt;
  logic [19:0] prop_gain_r, integ_gain_r, deriv_gain_r;
  logic [13:0] deadband_r;
  logic [7:0]  power_limit_r;

  logic [SAMPLE_BITS-1:0] sample_r, p_r, p_nxt;
  logic [7:0]             mode_r;
  logic signed [15:0]     radio_r, nav_r, angle_r, angle_nxt, setp;
  logic                   link_r, navok_r, gt_r, lt_r, dneg_r, gt_nxt, lt_nxt;
  logic [FW-1:0]          f_r, f_nxt;
  logic signed [47:0]     integ_r, integ_nxt;
  logic signed [17:0]     prev_r, err_r, err_nxt, dbe;
  logic [15:0]            diff_r, diff_nxt;
  logic signed [54:0]     t_r, h_r, t_abs, prod;
  logic signed [61:0]     iterm_r, iterm_nxt;
  logic signed [63:0]     sum_r, sum_nxt, ebias;
  logic signed [33:0]     mul_a;
  logic signed [20:0]     mul_b;
  logic signed [18:0]     derr;
  logic [55:0]            fsum;
  logic [FW:0]            psum;
  logic [16:0]            pe, ce;
  logic signed [41:0]     amag, aval, eff;
  logic [41:0]            eabs;
  logic signed [48:0]     isum;
  logic signed [69:0]     ifull;
  logic signed [40:0]     dterm;
  logic [15:0]            pz;
  logic [7:0]             lvl_v;
  logic                   left_v, wr_v;

  logic                 div_start, div_busy;
  logic [DIV_NW-1:0]    div_n, div_q;
  logic [DIV_DW-1:0]    div_d;

  assign dt   = (tick_period_r == '0) ? 16'd1 : tick_period_r;
  assign derr = 19'(err_r) - 19'(prev_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_FILT1: begin
        mul_a = signed'(34'(f_r));
        mul_b = signed'(21'(17'd65536 - {1'b0, filt_gain_r}));
      end
      OP_FILT2: begin
        mul_a = signed'(34'(filt_gain_r));
        mul_b = signed'(21'(sample_r));
      end
      OP_MAP_MUL: begin
        mul_a = signed'(34'(diff_r));
        mul_b = signed'(21'(ANGLE_LIMIT));
      end
      OP_INTEG: begin
        mul_a = 34'(err_r);
        mul_b = signed'(21'(dt));
      end
      OP_ILO: begin
        mul_a = signed'(34'(integ_r[23:0]));
        mul_b = signed'(21'(integ_gain_r));
      end
      OP_IHI: begin
        mul_a = 34'(signed'(integ_r[47:24]));
        mul_b = signed'(21'(integ_gain_r));
      end
      OP_DER_MUL: begin
        mul_a = 34'(derr);
        mul_b = signed'(21'(deriv_gain_r));
      end
      OP_PROP: begin
        mul_a = 34'(err_r);
        mul_b = signed'(21'(prop_gain_r));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // filter, rounding and angle map
  assign fsum  = 56'(t_r[48:0]) + (56'(prod[39:0]) << 16) + 56'd32768;
  assign f_nxt = fsum[FW+15:16];
  assign psum  = (FW+1)'(f_r) + (FW+1)'(32768);
  assign p_nxt = psum[FW-1:16];
  assign pe    = 17'(p_nxt);
  assign ce    = 17'(CENTER_POT);
  assign gt_nxt   = pe > ce;
  assign lt_nxt   = pe < ce;
  assign diff_nxt = gt_nxt ? 16'(pe - ce) : 16'(ce - pe);

  assign amag = signed'(42'(div_q));
  always_comb begin
    if (gt_r) begin
      aval = (DEN_L == 0) ? 42'(ANGLE_LIMIT) : ((DEN_L < 0) ? -amag : amag);
    end else if (lt_r) begin
      aval = (DEN_R == 0) ? -42'(ANGLE_LIMIT) : ((DEN_R < 0) ? amag : -amag);
    end else begin
      aval = '0;
    end
    if (aval > 42'sd32767) begin
      angle_nxt = 16'sh7fff;
    end else if (aval < -42'sd32768) begin
      angle_nxt = 16'sh8000;
    end else begin
      angle_nxt = aval[15:0];
    end
  end

  always_comb begin
    if (mode_r == MODE_NAV && link_r && navok_r) begin
      setp = nav_r;
    end else if (mode_r == MODE_RADIO && link_r) begin
      setp = radio_r;
    end else begin
      setp = '0;
    end
  end
  assign err_nxt = 18'(setp) - 18'(angle_r);

  // integral and its gain product
  assign isum      = 49'(integ_r) + 49'(signed'(prod[33:0]));
  assign integ_nxt = (isum[48] != isum[47]) ? (isum[48] ? IMIN : IMAX) : isum[47:0];
  assign ifull     = (70'(h_r) <<< 24) + 70'(t_r);
  always_comb begin
    if (ifull > TSAT) begin
      iterm_nxt = 62'(TSAT);
    end else if (ifull < -TSAT) begin
      iterm_nxt = 62'(-TSAT);
    end else begin
      iterm_nxt = 62'(ifull);
    end
  end

  // derivative divide and final sum
  assign t_abs   = t_r[54] ? -t_r : t_r;
  assign dterm   = dneg_r ? -signed'(41'(div_q)) : signed'(41'(div_q));
  assign sum_nxt = 64'(t_r) + 64'(iterm_r) + 64'(dterm);

  assign div_start = (cmd.op == OP_MAP_DIV) || (cmd.op == OP_DER_DIV);
  always_comb begin
    if (cmd.op == OP_MAP_DIV) begin
      div_n = 40'(t_r[31:0]) + 40'(gt_r ? HALF_L : HALF_R);
      div_d = 16'(gt_r ? MAG_L : MAG_R);
    end else begin
      div_n = t_abs[39:0];
      div_d = dt;
    end
  end

  spp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign stat.div_busy = div_busy;

  // effort, clamp and deadband
  assign ebias = sum_r + (sum_r[63] ? 64'sd4194303 : 64'sd0);
  assign eff   = ebias[63:22];
  assign eabs  = eff[41] ? 42'(-eff) : 42'(eff);
  assign dbe   = signed'(18'(deadband_r));
  always_comb begin
    lvl_v  = (eabs > 42'(power_limit_r)) ? power_limit_r : eabs[7:0];
    left_v = 1'b0;
    wr_v   = 1'b0;
    if (err_r > dbe) begin
      wr_v = 1'b1;
    end else if (err_r < -dbe) begin
      left_v = 1'b1;
      wr_v   = 1'b1;
    end else begin
      lvl_v = '0;
    end
  end
  assign pz = 16'(p_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_gain_r   <= 16'd6554;
      prop_gain_r   <= 20'd71680;
      integ_gain_r  <= '0;
      deriv_gain_r  <= '0;
      deadband_r    <= 14'd147;
      power_limit_r <= 8'd150;
      tick_period_r <= 16'd100;
      f_r           <= '0;
      integ_r       <= '0;
      prev_r        <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_FILTER_GAIN: filt_gain_r   <= cfg_data[15:0];
          CFG_PROP_GAIN:   prop_gain_r   <= cfg_data;
          CFG_INTEG_GAIN:  integ_gain_r  <= cfg_data;
          CFG_DERIV_GAIN:  deriv_gain_r  <= cfg_data;
          CFG_DEADBAND:    deadband_r    <= cfg_data[13:0];
          CFG_POWER_LIMIT: power_limit_r <= cfg_data[7:0];
          CFG_TICK_PERIOD: tick_period_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_FILT2) begin
        f_r <= f_nxt;
      end
      if (cmd.op == OP_INTEG) begin
        integ_r <= integ_nxt;
      end
      if (cmd.op == OP_DER_MUL) begin
        prev_r <= err_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        sample_r <= in_pot_sample;
        mode_r   <= in_mode;
        radio_r  <= in_radio_steer;
        nav_r    <= in_nav_steer;
        link_r   <= in_link_ok;
        navok_r  <= in_nav_ok;
      end
      OP_FILT1, OP_MAP_MUL, OP_ILO, OP_DER_MUL, OP_PROP: t_r <= prod;
      OP_IHI: h_r <= prod;
      OP_POT: begin
        p_r    <= p_nxt;
        gt_r   <= gt_nxt;
        lt_r   <= lt_nxt;
        diff_r <= diff_nxt;
      end
      OP_DER_DIV: dneg_r <= t_r[54];
      OP_ANGLE:   angle_r <= angle_nxt;
      OP_ERR:     err_r <= err_nxt;
      OP_ITERM:   iterm_r <= iterm_nxt;
      OP_SUM:     sum_r <= sum_nxt;
      OP_OUT: begin
        out_drive_level    <= lvl_v;
        out_drive_left     <= left_v;
        out_drive_write    <= wr_v;
        out_filtered_pot   <= (pz > 16'd4095) ? 12'd4095 : pz[11:0];
        out_measured_angle <= angle_r;
      end
      default: ;
    endcase
  end

endmodule

[rtl/core/spp_ctrl.sv]
// Sequencer: steps the datapath through one control tick and owns the
// channel handshakes. Depends on spp_pkg and the assertion macro header.
module spp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  spp_pkg::stat_t stat,
  output spp_pkg::cmd_t  cmd
);
  import spp_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt, out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd.op        = OP_NONE;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_MUL_F1;
        end
      end
      ST_MUL_F1:   begin cmd.op = OP_FILT1;   state_nxt = ST_MUL_F2;   end
      ST_MUL_F2:   begin cmd.op = OP_FILT2;   state_nxt = ST_POT;      end
      ST_POT:      begin cmd.op = OP_POT;     state_nxt = ST_MAP_MUL;  end
      ST_MAP_MUL:  begin cmd.op = OP_MAP_MUL; state_nxt = ST_MAP_DIVS; end
      ST_MAP_DIVS: begin cmd.op = OP_MAP_DIV; state_nxt = ST_MAP_WAIT; end
      ST_MAP_WAIT: begin
        if (!stat.div_busy) begin
          state_nxt = ST_ANGLE;
        end
      end
      ST_ANGLE:    begin cmd.op = OP_ANGLE;   state_nxt = ST_ERR;      end
      ST_ERR:      begin cmd.op = OP_ERR;     state_nxt = ST_INTEG;    end
      ST_INTEG:    begin cmd.op = OP_INTEG;   state_nxt = ST_ILO;      end
      ST_ILO:      begin cmd.op = OP_ILO;     state_nxt = ST_IHI;      end
      ST_IHI:      begin cmd.op = OP_IHI;     state_nxt = ST_ITERM;    end
      ST_ITERM:    begin cmd.op = OP_ITERM;   state_nxt = ST_DER_MUL;  end
      ST_DER_MUL:  begin cmd.op = OP_DER_MUL; state_nxt = ST_DER_DIVS; end
      ST_DER_DIVS: begin cmd.op = OP_DER_DIV; state_nxt = ST_DER_WAIT; end
      ST_DER_WAIT: begin
        if (!stat.div_busy) begin
          state_nxt = ST_PROP;
        end
      end
      ST_PROP:     begin cmd.op = OP_PROP;    state_nxt = ST_SUM;      end
      ST_SUM:      begin cmd.op = OP_SUM;     state_nxt = ST_OUT;      end
      ST_OUT: begin
        if (out_free) begin
          cmd.op        = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

`include "steering_position_pid_assert.svh"

  `SPP_ASSERT_NEXT(a_accept_starts, clk, rst_n, state_r == ST_IDLE && in_valid, state_r == ST_MUL_F1)
  `SPP_ASSERT_NEXT(a_div_hold, clk, rst_n, state_r == ST_MAP_WAIT && stat.div_busy, state_r == ST_MAP_WAIT)
  `SPP_ASSERT_NEXT(a_out_load, clk, rst_n, state_r == ST_OUT && out_free, out_valid_r && state_r == ST_IDLE)
  `SPP_ASSERT_SAME(a_div_start_idle, clk, rst_n, state_r == ST_DER_DIVS, !stat.div_busy)

endmodule

[tb/sv/tb.sv]
// Testbench for steering_position_pid: random and directed control ticks,
// a scoreboard class that predicts each result beat, and register phases.
// Depends on spp_pkg and the steering_position_pid RTL.
`timescale 1ns / 100ps

module tb;
  import spp_pkg::*;

  localparam longint LEFT_POT    = 3210;
  localparam longint CENTER_POT  = 1730;
  localparam longint RIGHT_POT   = 490;
  localparam longint ANGLE_LIMIT = 15729;
  localparam longint INTEG_MAX   = 64'sd140737488355327;
  localparam longint INTEG_MIN   = -INTEG_MAX - 1;
  localparam longint TERM_SAT    = 64'sd1 << 60;

  typedef struct {
    logic [11:0]        pot_sample;
    logic [7:0]         mode;
    logic signed [15:0] radio_steer;
    logic signed [15:0] nav_steer;
    logic               link_ok;
    logic               nav_ok;
  } tick_t;

  typedef struct {
    logic [7:0]         drive_level;
    logic               drive_left;
    logic               drive_write;
    logic [11:0]        filtered_pot;
    logic signed [15:0] measured_angle;
  } drive_t;

  class steer_scoreboard;
    longint filter_gain, prop_gain, integ_gain, deriv_gain;
    longint deadband, power_limit, tick_period;
    longint filt_acc, err_sum, last_err;
    drive_t pending[$];
    int     fails;

    function new();
      filter_gain = 6554; prop_gain = 71680; integ_gain = 0; deriv_gain = 0;
      deadband = 147; power_limit = 150; tick_period = 100;
      filt_acc = 0; err_sum = 0; last_err = 0; fails = 0;
    endfunction

    function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
      case (idx)
        CFG_FILTER_GAIN: filter_gain = val[15:0];
        CFG_PROP_GAIN:   prop_gain   = val;
        CFG_INTEG_GAIN:  integ_gain  = val;
        CFG_DERIV_GAIN:  deriv_gain  = val;
        CFG_DEADBAND:    deadband    = val[13:0];
        CFG_POWER_LIMIT: power_limit = val[7:0];
        CFG_TICK_PERIOD: tick_period = val[15:0];
        default: ;
      endcase
    endfunction

    function longint round_div(longint num, longint den);
      longint n, d, q;
      n = num < 0 ? -num : num;
      d = den < 0 ? -den : den;
      q = (n + d / 2) / d;
      return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function void note_tick(tick_t t);
      longint dt, pos, ang, setp, err, iterm, dterm, total, eff;
      drive_t r;
      dt = tick_period != 0 ? tick_period : 1;
      filt_acc = ((65536 - filter_gain) * filt_acc
                  + filter_gain * (longint'(t.pot_sample) << 16) + 32768) >>> 16;
      pos = (filt_acc + 32768) >>> 16;
      if (pos > CENTER_POT)
        ang = round_div((pos - CENTER_POT) * ANGLE_LIMIT, LEFT_POT - CENTER_POT);
      else if (pos < CENTER_POT)
        ang = -round_div((CENTER_POT - pos) * ANGLE_LIMIT, CENTER_POT - RIGHT_POT);
      else
        ang = 0;
      if (ang > 32767) ang = 32767;
      if (ang < -32768) ang = -32768;
      if (t.mode == MODE_NAV && t.link_ok && t.nav_ok) setp = t.nav_steer;
      else if (t.mode == MODE_RADIO && t.link_ok) setp = t.radio_steer;
      else setp = 0;
      err = setp - ang;
      err_sum += err * dt;
      if (err_sum > INTEG_MAX) err_sum = INTEG_MAX;
      if (err_sum < INTEG_MIN) err_sum = INTEG_MIN;
      if (integ_gain != 0 && (err_sum > TERM_SAT / integ_gain ||
                              err_sum < -(TERM_SAT / integ_gain)))
        iterm = err_sum > 0 ? TERM_SAT : -TERM_SAT;
      else
        iterm = integ_gain * err_sum;
      dterm = ((err - last_err) * deriv_gain) / dt;
      last_err = err;
      total = prop_gain * err + iterm + dterm;
      eff = total / (64'sd1 << 22);
      if (eff < -power_limit) eff = -power_limit;
      if (eff > power_limit) eff = power_limit;
      r.drive_level = 0; r.drive_left = 0; r.drive_write = 0;
      if (err > deadband || err < -deadband) begin
        r.drive_level = 8'(eff < 0 ? -eff : eff);
        r.drive_write = 1;
        r.drive_left  = err < 0;
      end
      r.filtered_pot   = 12'(pos > 4095 ? 4095 : pos);
      r.measured_angle = 16'(ang);
      pending.push_back(r);
    endfunction

    function void check_drive(drive_t got);
      drive_t exp_r;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected");
        fails++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.drive_level !== exp_r.drive_level) begin
        $error("drive_level exp %0d got %0d", exp_r.drive_level, got.drive_level); fails++;
      end
      if (got.drive_left !== exp_r.drive_left) begin
        $error("drive_left exp %0d got %0d", exp_r.drive_left, got.drive_left); fails++;
      end
      if (got.drive_write !== exp_r.drive_write) begin
        $error("drive_write exp %0d got %0d", exp_r.drive_write, got.drive_write); fails++;
      end
      if (got.filtered_pot !== exp_r.filtered_pot) begin
        $error("filtered_pot exp %0d got %0d", exp_r.filtered_pot, got.filtered_pot);
        fails++;
      end
      if (got.measured_angle !== exp_r.measured_angle) begin
        $error("measured_angle exp %0d got %0d", exp_r.measured_angle, got.measured_angle);
        fails++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [11:0] in_pot_sample;
  logic [7:0] in_mode;
  logic signed [15:0] in_radio_steer, in_nav_steer;
  logic in_link_ok, in_nav_ok;
  logic out_valid, out_stall;
  logic [7:0] out_drive_level;
  logic out_drive_left, out_drive_write;
  logic [11:0] out_filtered_pot;
  logic signed [15:0] out_measured_angle;
  logic cfg_valid, cfg_ready;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  steer_scoreboard sb;
  bit calm;

  steering_position_pid i_dut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) out_stall <= !calm && rst_n && ($urandom_range(99) < 15);

  always @(posedge clk) begin
    tick_t t;
    drive_t d;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        t.pot_sample = in_pot_sample; t.mode = in_mode;
        t.radio_steer = in_radio_steer; t.nav_steer = in_nav_steer;
        t.link_ok = in_link_ok; t.nav_ok = in_nav_ok;
        sb.note_tick(t);
      end
      if (out_valid && !out_stall) begin
        d.drive_level = out_drive_level; d.drive_left = out_drive_left;
        d.drive_write = out_drive_write; d.filtered_pot = out_filtered_pot;
        d.measured_angle = out_measured_angle;
        sb.check_drive(d);
      end
    end
  end

  task automatic send_tick(tick_t t);
    while (!calm && $urandom_range(99) < 15) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_pot_sample <= t.pot_sample; in_mode <= t.mode;
    in_radio_steer <= t.radio_steer; in_nav_steer <= t.nav_steer;
    in_link_ok <= t.link_ok; in_nav_ok <= t.nav_ok;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send(int pot, int mode, int radio, int nav, bit link, bit navok);
    tick_t t;
    t.pot_sample = 12'(pot); t.mode = 8'(mode);
    t.radio_steer = 16'(radio); t.nav_steer = 16'(nav);
    t.link_ok = link; t.nav_ok = navok;
    send_tick(t);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, longint val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= CFG_DW'(val);
    do @(posedge clk); while (!cfg_ready);
  endtask

  function automatic longint pick(longint hi, longint typ);
    case ($urandom_range(5))
      0: return 0;
      1: return hi;
      default: return $urandom_range(32'(typ));
    endcase
  endfunction

  task automatic random_config();
    write_reg(CFG_FILTER_GAIN, pick(65535, 65535));
    write_reg(CFG_PROP_GAIN, pick(1048575, 300000));
    write_reg(CFG_INTEG_GAIN, pick(1048575, 2000));
    write_reg(CFG_DERIV_GAIN, pick(1048575, 1048575));
    write_reg(CFG_DEADBAND, pick(16383, 2000));
    write_reg(CFG_POWER_LIMIT, pick(255, 255));
    write_reg(CFG_TICK_PERIOD, pick(65535, 1000));
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic random_tick();
    tick_t t;
    t.pot_sample = 12'($urandom);
    t.radio_steer = 16'($urandom);
    t.nav_steer = 16'($urandom);
    if ($urandom_range(9) < 8) begin
      t.mode = $urandom_range(1) ? MODE_RADIO : MODE_NAV;
      t.link_ok = $urandom_range(9) != 0;
      t.nav_ok = $urandom_range(9) != 0;
      if ($urandom_range(3) == 0) begin
        t.radio_steer = $signed(16'($urandom_range(4000))) - 16'sd2000;
        t.nav_steer = t.radio_steer;
      end
    end else begin
      t.mode = 8'($urandom);
      t.link_ok = 1'($urandom);
      t.nav_ok = 1'($urandom);
    end
    send_tick(t);
  endtask

  initial begin
    sb = new();
    calm = 0;
    rst_n = 0;
    in_valid = 0; in_pot_sample = 0; in_mode = 0; in_radio_steer = 0;
    in_nav_steer = 0; in_link_ok = 0; in_nav_ok = 0;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send(4095, MODE_RADIO, 32767, 0, 1, 0);
    send(4095, MODE_RADIO, -32768, 0, 1, 0);
    send(0, MODE_NAV, 0, 32767, 1, 1);
    send(0, MODE_NAV, 0, -32768, 1, 0);
    send(1730, 0, 1000, 1000, 1, 1);
    send(2000, 255, -1000, -1000, 1, 1);
    drain();

    write_reg(CFG_FILTER_GAIN, 65535);
    write_reg(CFG_INTEG_GAIN, 1048575);
    write_reg(CFG_DERIV_GAIN, 5000);
    write_reg(CFG_TICK_PERIOD, 0);
    write_reg(CFG_DEADBAND, 0);
    cfg_valid <= 0;
    @(posedge clk);
    send(1730, MODE_RADIO, 0, 0, 1, 0);
    send(0, MODE_RADIO, -32768, 0, 1, 0);
    send(4095, MODE_RADIO, 32767, 0, 1, 0);
    send(3210, MODE_NAV, 0, -32768, 1, 1);
    send(490, MODE_NAV, 0, 32767, 1, 1);
    send(1731, MODE_RADIO, 300, 0, 0, 1);
    send(1729, 3, 300, 300, 1, 1);
    send(2500, MODE_RADIO, -5000, 0, 1, 0);
    send(900, MODE_RADIO, 5000, 0, 1, 0);
    drain();

    write_reg(CFG_PROP_GAIN, 1048575);
    write_reg(CFG_POWER_LIMIT, 255);
    write_reg(CFG_DEADBAND, 16383);
    cfg_valid <= 0;
    @(posedge clk);
    send(0, MODE_NAV, 0, 32767, 1, 1);
    send(4095, MODE_NAV, 0, -32768, 1, 1);
    send(1730, MODE_RADIO, 100, 0, 1, 0);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      random_config();
      calm = (ph == 4);
      for (int k = 0; k < 200; k++) random_tick();
      calm = 0;
      drain();
    end

    if (sb.fails == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
